/* hdl/rbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared types, constants and per-stage helpers for range and bearing.
// ----------------------------------------------------------------------------
package rbt_pkg;

   // stage layout of the pipeline
   localparam int STAGES       = 29;
   localparam int SQRT_FIRST   = 4;
   localparam int SQRT_STEPS   = 25;
   localparam int CORDIC_STEPS = 16;
   localparam int POST_FIRST   = SQRT_FIRST + CORDIC_STEPS;

   // angles in degrees with 16 fractional bits (FULL8 with 8)
   localparam logic signed [29:0] FULL16   = 30'sd23592960;
   localparam logic signed [29:0] QUART16  = 30'sd5898240;
   localparam logic signed [44:0] HALF16   = 45'sd11796480;
   localparam logic [20:0]        FULL8    = 21'd92160;
   localparam logic [5:0]         NORM_MSB = 6'd40;

   typedef struct packed {
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [24:0] dz;
      logic signed [18:0] heading;
      logic               coin;
      logic [47:0]        sqx;
      logic [47:0]        sqy;
      logic [47:0]        sqz;
      logic [49:0]        rem;
      logic [49:0]        root;
      logic signed [44:0] cx;
      logic signed [44:0] cy;
      logic signed [25:0] ang;
      logic [24:0]        orm;
      logic [5:0]         sh;
      logic signed [29:0] t;
      logic [16:0]        bearing;
   } pipe_type;

   // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
   function automatic logic signed [25:0] atan_deg(input int i);
      logic [21:0] a;
      begin
         case (i)
            0: a = 22'd2949120;
            1: a = 22'd1740967;
            2: a = 22'd919879;
            3: a = 22'd466945;
            4: a = 22'd234379;
            5: a = 22'd117304;
            6: a = 22'd58666;
            7: a = 22'd29335;
            8: a = 22'd14668;
            9: a = 22'd7334;
            10: a = 22'd3667;
            11: a = 22'd1833;
            12: a = 22'd917;
            13: a = 22'd458;
            14: a = 22'd229;
            15: a = 22'd115;
            16: a = 22'd57;
            17: a = 22'd29;
            18: a = 22'd14;
            19: a = 22'd7;
            20: a = 22'd4;
            21: a = 22'd2;
            22: a = 22'd1;
            default: a = 22'd0;
         endcase
         atan_deg = signed'({4'd0, a});
      end
   endfunction

   // position of the highest set bit
   function automatic logic [4:0] msb_pos(input logic [24:0] v);
      logic [4:0] p;
      begin
         p = 5'd0;
         for (int b = 0; b < 25; b++) begin
            if (v[b]) p = 5'(b);
         end
         msb_pos = p;
      end
   endfunction

endpackage

/* hdl/rbt_stage_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbt_stage_ctrl
// Valid bits and per-stage load enables of the elastic pipeline.
// ----------------------------------------------------------------------------
module rbt_stage_ctrl
   import rbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] load
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // a stage loads when empty or when its contents move on
   always_comb begin
      load[STAGES-1] = ~valid_ff[STAGES-1] | out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = ~valid_ff[k] | load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

/* hdl/range_and_bearing_to_target.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_and_bearing_to_target
// Distance and relative bearing from an object to a target point.
// ----------------------------------------------------------------------------
// One item enters per cycle while req_ready is high; the pipeline depth is
// set by the 25-step square root, one result bit per stage, with
// the 16-stage vectoring CORDIC and the bearing wrap running beside it. The
// pipeline is elastic: a stalled result holds only the stages behind it and
// empty stages keep filling. Distance is floor(sqrt(dx^2+dy^2+dz^2)); bearing
// is the X/Z offset angle plus heading plus 90 degrees, wrapped to [0,360)
// with 8 fractional bits; coincident flags a zero X/Z offset (bearing 0).
module range_and_bearing_to_target
   import rbt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_own_x,
   input  logic signed [23:0] req_own_y,
   input  logic signed [23:0] req_own_z,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic signed [23:0] req_target_z,
   input  logic signed [18:0] req_own_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_distance,
   output logic [16:0]        rsp_bearing,
   output logic               rsp_coincident
);

   logic [STAGES-1:0] load;
   pipe_type          pipe_ff [STAGES];
   pipe_type          pipe_in [STAGES];

   rbt_stage_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .load      (load)
   );

   // offsets of the incoming item
   always_comb begin
      pipe_in[0]         = '0;
      pipe_in[0].dx      = {req_target_x[23], req_target_x} - {req_own_x[23], req_own_x};
      pipe_in[0].dy      = {req_target_y[23], req_target_y} - {req_own_y[23], req_own_y};
      pipe_in[0].dz      = {req_target_z[23], req_target_z} - {req_own_z[23], req_own_z};
      pipe_in[0].heading = req_own_heading;
      pipe_in[0].coin    = (req_target_x == req_own_x) && (req_target_z == req_own_z);
   end

   for (genvar k = 1; k < STAGES; k++) begin : g_stage
      localparam int J = k - SQRT_FIRST;
      always_comb begin
         logic [23:0]        ax, ay, az;
         logic [24:0]        my;
         logic [49:0]        bitv, trial;
         logic signed [44:0] xs, ys;
         logic [20:0]        r;
         pipe_in[k] = pipe_ff[k-1];
         ax = '0; ay = '0; az = '0; my = '0;
         bitv = '0; trial = '0; xs = '0; ys = '0; r = '0;
         // squares; fold the offset into the right half plane
         if (k == 1) begin
            ax = pipe_ff[k-1].dx[24] ? 24'(-pipe_ff[k-1].dx) : pipe_ff[k-1].dx[23:0];
            ay = pipe_ff[k-1].dy[24] ? 24'(-pipe_ff[k-1].dy) : pipe_ff[k-1].dy[23:0];
            az = pipe_ff[k-1].dz[24] ? 24'(-pipe_ff[k-1].dz) : pipe_ff[k-1].dz[23:0];
            pipe_in[k].sqx = 48'(ax) * 48'(ax);
            pipe_in[k].sqy = 48'(ay) * 48'(ay);
            pipe_in[k].sqz = 48'(az) * 48'(az);
            if (pipe_ff[k-1].dx[24]) begin
               pipe_in[k].cx  = -45'(pipe_ff[k-1].dx);
               pipe_in[k].cy  = -45'(pipe_ff[k-1].dz);
               pipe_in[k].ang = 26'(HALF16);
            end else begin
               pipe_in[k].cx  = 45'(pipe_ff[k-1].dx);
               pipe_in[k].cy  = 45'(pipe_ff[k-1].dz);
               pipe_in[k].ang = '0;
            end
            my = pipe_in[k].cy[44] ? 25'(-pipe_in[k].cy) : pipe_in[k].cy[24:0];
            pipe_in[k].orm = pipe_in[k].cx[24:0] | my;
         end
         // sum of squares; normalizing shift amount
         if (k == 2) begin
            pipe_in[k].rem  = 50'(pipe_ff[k-1].sqx) + 50'(pipe_ff[k-1].sqy)
                              + 50'(pipe_ff[k-1].sqz);
            pipe_in[k].root = '0;
            pipe_in[k].sh   = NORM_MSB - {1'b0, msb_pos(pipe_ff[k-1].orm)};
         end
         // normalize the larger part to [2^40, 2^41)
         if (k == 3) begin
            pipe_in[k].cx = pipe_ff[k-1].cx <<< pipe_ff[k-1].sh;
            pipe_in[k].cy = pipe_ff[k-1].cy <<< pipe_ff[k-1].sh;
         end
         // one bit of the square root
         if (J >= 0 && J < SQRT_STEPS) begin
            bitv  = 50'(1) << (2 * (SQRT_STEPS - 1 - J));
            trial = pipe_ff[k-1].root + bitv;
            if (pipe_ff[k-1].rem >= trial) begin
               pipe_in[k].rem  = pipe_ff[k-1].rem - trial;
               pipe_in[k].root = (pipe_ff[k-1].root >> 1) + bitv;
            end else begin
               pipe_in[k].root = pipe_ff[k-1].root >> 1;
            end
         end
         // one vectoring rotation
         if (J >= 0 && J < CORDIC_STEPS) begin
            xs = pipe_ff[k-1].cx >>> J;
            ys = pipe_ff[k-1].cy >>> J;
            if (!pipe_ff[k-1].cy[44]) begin
               pipe_in[k].cx  = pipe_ff[k-1].cx + ys;
               pipe_in[k].cy  = pipe_ff[k-1].cy - xs;
               pipe_in[k].ang = pipe_ff[k-1].ang + atan_deg(J);
            end else begin
               pipe_in[k].cx  = pipe_ff[k-1].cx - ys;
               pipe_in[k].cy  = pipe_ff[k-1].cy + xs;
               pipe_in[k].ang = pipe_ff[k-1].ang - atan_deg(J);
            end
         end
         // add heading and 90 degrees, offset to keep the sum positive
         if (k == POST_FIRST) begin
            pipe_in[k].t = 30'(pipe_ff[k-1].ang) + (30'(pipe_ff[k-1].heading) <<< 8)
                           + QUART16 + (FULL16 <<< 2);
         end
         // reduce modulo 360 degrees
         if (k == POST_FIRST + 1) begin
            if (pipe_ff[k-1].t >= (FULL16 <<< 2)) pipe_in[k].t = pipe_ff[k-1].t - (FULL16 <<< 2);
         end
         if (k == POST_FIRST + 2) begin
            if (pipe_ff[k-1].t >= (FULL16 <<< 1)) pipe_in[k].t = pipe_ff[k-1].t - (FULL16 <<< 1);
         end
         if (k == POST_FIRST + 3) begin
            if (pipe_ff[k-1].t >= FULL16) pipe_in[k].t = pipe_ff[k-1].t - FULL16;
         end
         // round to 8 fractional bits, fold 360 to 0 and zero a coincident item
         if (k == POST_FIRST + 4) begin
            r = 21'((pipe_ff[k-1].t + 30'sd128) >>> 8);
            if (r >= FULL8 || pipe_ff[k-1].coin) r = '0;
            pipe_in[k].bearing = r[16:0];
         end
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (load[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_distance   = pipe_ff[STAGES-1].root[25:0];
   assign rsp_bearing    = pipe_ff[STAGES-1].bearing;
   assign rsp_coincident = pipe_ff[STAGES-1].coin;

   // checks
   a_coin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |-> rsp_bearing == 17'd0)
      else $error("coincident item with nonzero bearing");

   a_bear_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing < 17'd92160)
      else $error("bearing outside one turn");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled result changed");

endmodule
